/* sv/fss_pkg.sv */
// ----------------------------------------------------------------------------
// fss_pkg
// Shared types, codes and constants of the filtered space-saving tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package fss_pkg;

   localparam int KEY_W = 64;
   localparam int LEN_W = 4;
   localparam int CNT_W = 32;

   localparam logic [31:0] HASH_SEED = 32'hbc9f1d34;
   localparam logic [31:0] HASH_MUL  = 32'hc6a4a793;

   // opcodes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_READ   = 1'b1;

   // result status codes
   localparam logic [2:0] STATUS_HIT      = 3'd0;
   localparam logic [2:0] STATUS_ADDED    = 3'd1;
   localparam logic [2:0] STATUS_FILTERED = 3'd2;
   localparam logic [2:0] STATUS_REPLACED = 3'd3;
   localparam logic [2:0] STATUS_READ     = 3'd4;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [LEN_W-1:0] len;
      logic [CNT_W-1:0] count;
      logic [CNT_W-1:0] err;
   } entry_type;

   typedef struct packed {
      logic load;
      logic inc;
      logic take_prev;
      logic take_next;
   } cell_ctrl_type;

   // true when entry a sorts below entry b
   function automatic logic ranks_below(entry_type a, entry_type b);
      return (a.count < b.count) || ((a.count == b.count) && (a.err > b.err));
   endfunction

endpackage

`default_nettype wire

/* sv/fss_req_if.sv */
// ----------------------------------------------------------------------------
// fss_req_if
// Request channel: insert or read items with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fss_req_if;
   import fss_pkg::*;

   logic             valid;
   logic             ready;
   logic             opcode;
   logic [KEY_W-1:0] key_bytes;
   logic [LEN_W-1:0] key_len;
   logic [3:0]       read_rank;

   modport source (output valid, opcode, key_bytes, key_len, read_rank, input ready);
   modport sink   (input valid, opcode, key_bytes, key_len, read_rank, output ready);
endinterface

`default_nettype wire

/* sv/fss_rsp_if.sv */
// ----------------------------------------------------------------------------
// fss_rsp_if
// Response channel: one result item per request item.
// ----------------------------------------------------------------------------
`default_nettype none

interface fss_rsp_if;
   import fss_pkg::*;

   logic             valid;
   logic             ready;
   logic [2:0]       status;
   logic [3:0]       rank;
   logic             entry_valid;
   logic [KEY_W-1:0] out_key;
   logic [LEN_W-1:0] out_len;
   logic [CNT_W-1:0] count;
   logic [CNT_W-1:0] error_bound;

   modport source (output valid, status, rank, entry_valid, out_key, out_len, count,
                   error_bound, input ready);
   modport sink   (input valid, status, rank, entry_valid, out_key, out_len, count,
                   error_bound, output ready);
endinterface

`default_nettype wire

/* sv/fss_cell.sv */
// ----------------------------------------------------------------------------
// fss_cell
// One list slot: holds an entry, matches it against the query key and
// swaps with its upper neighbor during bubble moves.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_cell (
   input  wire                   clock,
   input  fss_pkg::cell_ctrl_type ctrl,
   input  fss_pkg::entry_type     load_entry,
   input  fss_pkg::entry_type     prev_entry,
   input  fss_pkg::entry_type     next_entry,
   input  wire [63:0]            query_key,
   input  wire [3:0]             query_len,
   output fss_pkg::entry_type     entry,
   output logic                  match,
   output logic                  swap_req
);
   import fss_pkg::*;

   entry_type entry_ff;

   // slot update: load, neighbor swap or count increment
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         entry_ff <= load_entry;
      end else if (ctrl.take_prev) begin
         entry_ff <= prev_entry;
      end else if (ctrl.take_next) begin
         entry_ff <= next_entry;
      end else if (ctrl.inc && (entry_ff.count != '1)) begin
         entry_ff.count <= entry_ff.count + 32'd1;
      end
   end

   assign entry    = entry_ff;
   assign match    = (entry_ff.len == query_len) && (entry_ff.key == query_key);
   assign swap_req = ranks_below(prev_entry, entry_ff);

endmodule

`default_nettype wire

/* sv/fss_hash.sv */
// ----------------------------------------------------------------------------
// fss_hash
// Iterative key hash, one add, multiply or xor per cycle, followed by a
// remainder by the bucket count through a reciprocal multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_hash #(
   parameter int HASH_BUCKETS = 96
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             start,
   input  wire [63:0]                      key,
   input  wire [3:0]                       len,
   output logic                            done,
   output logic [$clog2(HASH_BUCKETS)-1:0] bucket
);
   import fss_pkg::*;

   localparam int BW  = $clog2(HASH_BUCKETS);
   localparam int SH2 = BW - 1;
   // reciprocal for an exact 32-bit quotient by the bucket count
   localparam logic [63:0] REC64 =
      ((((64'd1 << BW) - 64'(HASH_BUCKETS)) << 32) / 64'(HASH_BUCKETS)) + 64'd1;
   localparam logic [31:0] REC = REC64[31:0];
   localparam logic [31:0] NB  = 32'(HASH_BUCKETS);

   typedef enum logic [6:0] {
      H_IDLE = 7'b0000001,
      H_ADD  = 7'b0000010,
      H_MUL  = 7'b0000100,
      H_XOR  = 7'b0001000,
      H_QHI  = 7'b0010000,
      H_QUO  = 7'b0100000,
      H_REM  = 7'b1000000
   } hstate_type;

   hstate_type  state_ff, state_in;
   logic [31:0] h_ff, h_in;
   logic [63:0] key_ff;
   logic [3:0]  len_ff;
   logic        widx_ff, widx_in;
   logic [31:0] q_ff, q_in;
   logic [BW-1:0] rem_ff, rem_in;
   logic        done_ff, done_in;
   logic [1:0]  rounds;
   logic [63:0] rec_prod;
   logic [63:0] nb_prod;
   logic [31:0] rem_full;

   assign rounds   = len_ff[3:2] + {1'b0, |len_ff[1:0]};
   assign rec_prod = {32'd0, h_ff} * {32'd0, REC};
   assign nb_prod  = {32'd0, q_ff} * {32'd0, NB};
   assign rem_full = h_ff - nb_prod[31:0];

   // sequencer
   always_comb begin
      state_in = state_ff;
      h_in     = h_ff;
      widx_in  = widx_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      case (state_ff)
         H_IDLE: begin
            if (start) begin
               h_in     = HASH_SEED ^ (32'(len) * HASH_MUL);
               widx_in  = 1'b0;
               state_in = ((len[3:2] == 2'd0) && (len[1:0] == 2'd0)) ? H_QHI : H_ADD;
            end
         end
         H_ADD: begin
            h_in     = h_ff + (widx_ff ? key_ff[63:32] : key_ff[31:0]);
            state_in = H_MUL;
         end
         H_MUL: begin
            h_in     = h_ff * HASH_MUL;
            state_in = H_XOR;
         end
         H_XOR: begin
            // full words fold by 16, the tail word by 24
            if ({1'b0, widx_ff} < len_ff[3:2]) begin
               h_in = h_ff ^ (h_ff >> 16);
            end else begin
               h_in = h_ff ^ (h_ff >> 24);
            end
            if (({1'b0, widx_ff} + 2'd1) == rounds) begin
               state_in = H_QHI;
            end else begin
               widx_in  = 1'b1;
               state_in = H_ADD;
            end
         end
         H_QHI: begin
            // high half of hash times reciprocal
            q_in     = rec_prod[63:32];
            state_in = H_QUO;
         end
         H_QUO: begin
            // quotient correction and final shift
            q_in     = (q_ff + ((h_ff - q_ff) >> 1)) >> SH2;
            state_in = H_REM;
         end
         H_REM: begin
            rem_in   = rem_full[BW-1:0];
            done_in  = 1'b1;
            state_in = H_IDLE;
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff    <= h_in;
      widx_ff <= widx_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      if ((state_ff == H_IDLE) && start) begin
         key_ff <= key;
         len_ff <= len;
      end
   end

   assign done   = done_ff;
   assign bucket = rem_ff;

endmodule

`default_nettype wire

/* sv/filtered_space_saving_topk.sv */
// ----------------------------------------------------------------------------
// filtered_space_saving_topk
// Top-k frequency tracker with filtered space-saving over a row of cells.
// ----------------------------------------------------------------------------
// Usage: req_chan carries insert items (opcode 0, key bytes and length) and
// read items (opcode 1, rank). Every request item yields exactly one item on
// rsp_chan, in order. Items are taken one at a time.
// A read goes from the idle state straight to the output state. An insert
// first runs the hash unit: add, multiply and fold per 4-byte word, up to 2
// words, then the reciprocal remainder and the hand-over of the bucket; then
// a bucket read, the decision, the bubble moves through the cell row (up to
// CAPACITY-1), a settling step and the load into the output register. A
// replacement of the minimum adds a second hash of the evicted key, a second
// bucket read and the bucket updates of the evicted key and, where its bucket
// differs, of the new key.
// Reset clears the fill level and the bucket valid bits, so the block accepts
// items right after reset; list cells need no clearing.
// When the receiver stalls, the result waits in the output register and the
// next request item is still accepted and worked on up to its result.
// ----------------------------------------------------------------------------
`default_nettype none

module filtered_space_saving_topk #(
   parameter int CAPACITY      = 16,
   parameter int HASH_BUCKETS  = 96,
   parameter int MAX_KEY_BYTES = 8
) (
   input  wire      clock,
   input  wire      reset,
   fss_req_if.sink  req_chan,
   fss_rsp_if.source rsp_chan
);
   import fss_pkg::*;

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int FW = $clog2(CAPACITY + 1);
   localparam int BW = $clog2(HASH_BUCKETS);
   localparam logic [3:0]    MAXLEN = 4'(MAX_KEY_BYTES);
   localparam logic [FW-1:0] CAP_F  = FW'(CAPACITY);

   typedef struct packed {
      logic [FW-1:0] tracked;
      logic [31:0]   alpha;
   } bucket_type;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_HASH  = 10'b0000000010,
      S_BRD   = 10'b0000000100,
      S_DEC   = 10'b0000001000,
      S_HASH2 = 10'b0000010000,
      S_BRD2  = 10'b0000100000,
      S_DEC2  = 10'b0001000000,
      S_WRH   = 10'b0010000000,
      S_BUB   = 10'b0100000000,
      S_OUT   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // request item registers
   logic          op_ff;
   logic [63:0]   key_ff;
   logic [3:0]    len_ff;
   logic [3:0]    rrank_ff;
   logic [2:0]    status_ff, status_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [CAPACITY-1:0] cur_ff, cur_in;
   logic [BW-1:0] bkt_h_ff, bkt2_ff;
   bucket_type    bd_h_ff;

   // output register
   logic          out_valid_ff;
   logic [2:0]    o_status_ff;
   logic [3:0]    o_rank_ff;
   logic          o_valid_ff;
   logic [63:0]   o_key_ff;
   logic [3:0]    o_len_ff;
   logic [31:0]   o_count_ff, o_err_ff;

   // bucket memory
   bucket_type            bmem [HASH_BUCKETS];
   logic [HASH_BUCKETS-1:0] bvalid_ff;
   bucket_type            brd_data_ff;
   logic                  brd_valid_ff;
   logic [BW-1:0]         brd_addr;
   logic                  bwr_en;
   logic [BW-1:0]         bwr_addr;
   bucket_type            bwr_data;
   bucket_type            bd;

   // hash unit
   logic          hash_start;
   logic [63:0]   hash_key;
   logic [3:0]    hash_len;
   logic          hash_done;
   logic [BW-1:0] hash_bucket;

   // cell row
   entry_type     cells [CAPACITY];
   cell_ctrl_type cctrl [CAPACITY];
   logic [CAPACITY-1:0] match_raw, swap_req, swap;
   logic [CAPACITY-1:0] fill_mask, match_vec, load_sel;
   logic          load_any, inc_any;
   entry_type     load_entry;
   logic [31:0]   load_err;

   // request key clamp and mask
   logic [3:0]    len_c;
   logic [63:0]   key_m;
   logic          out_free;
   logic          acc;

   entry_type     last_entry;
   entry_type     pos_entry, rank_entry;
   logic [31:0]   pos_w;
   logic          rank_hit;

   always_comb begin
      len_c = (req_chan.key_len > MAXLEN) ? MAXLEN : req_chan.key_len;
      for (int b = 0; b < 8; b++) begin
         key_m[b*8 +: 8] = (4'(b) < len_c) ? req_chan.key_bytes[b*8 +: 8] : 8'd0;
      end
   end

   assign req_chan.ready = (state_ff == S_IDLE);
   assign acc            = req_chan.valid && (state_ff == S_IDLE);
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign last_entry     = cells[CAPACITY-1];
   assign bd             = brd_valid_ff ? brd_data_ff : '0;

   // tracked and selection masks over the row
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         fill_mask[i] = (FW'(i) < fill_ff);
         load_sel[i]  = (fill_ff == FW'(i));
      end
      match_vec = match_raw & fill_mask;
   end

   generate
      for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
         entry_type prev_e, next_e;
         assign prev_e = (g == 0) ? cells[g] : cells[(g == 0) ? 0 : g - 1];
         assign next_e = (g == CAPACITY - 1) ? cells[g]
                                             : cells[(g == CAPACITY - 1) ? g : g + 1];
         fss_cell u_cell (
            .clock      (clock),
            .ctrl       (cctrl[g]),
            .load_entry (load_entry),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .query_key  (key_ff),
            .query_len  (len_ff),
            .entry      (cells[g]),
            .match      (match_raw[g]),
            .swap_req   (swap_req[g])
         );
      end
   endgenerate

   // bubble moves: the current slot swaps with its upper neighbor while that neighbor ranks below it
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         swap[i] = (state_ff == S_BUB) && cur_ff[i] && (i != 0) && swap_req[i];
      end
   end

   fss_hash #(.HASH_BUCKETS(HASH_BUCKETS)) u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .key    (hash_key),
      .len    (hash_len),
      .done   (hash_done),
      .bucket (hash_bucket)
   );

   // control sequencer
   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      fill_in    = fill_ff;
      cur_in     = cur_ff;
      hash_start = 1'b0;
      hash_key   = key_m;
      hash_len   = len_c;
      brd_addr   = bkt_h_ff;
      bwr_en     = 1'b0;
      bwr_addr   = bkt_h_ff;
      bwr_data   = bd;
      load_any   = 1'b0;
      inc_any    = 1'b0;
      load_err   = 32'd0;
      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               if (req_chan.opcode == OP_READ) begin
                  status_in = STATUS_READ;
                  state_in  = S_OUT;
               end else begin
                  hash_start = 1'b1;
                  state_in   = S_HASH;
               end
            end
         end
         S_HASH: begin
            if (hash_done) begin
               state_in = S_BRD;
            end
         end
         S_BRD: begin
            brd_addr = bkt_h_ff;
            state_in = S_DEC;
         end
         S_DEC: begin
            if ((bd.tracked != '0) && (match_vec != '0)) begin
               inc_any   = 1'b1;
               cur_in    = match_vec;
               status_in = STATUS_HIT;
               state_in  = S_BUB;
            end else if (fill_ff < CAP_F) begin
               load_any  = 1'b1;
               cur_in    = load_sel;
               fill_in   = fill_ff + FW'(1);
               bwr_en    = 1'b1;
               bwr_data  = '{tracked: bd.tracked + FW'(1), alpha: bd.alpha};
               status_in = STATUS_ADDED;
               state_in  = S_BUB;
            end else if (({1'b0, bd.alpha} + 33'd1) < {1'b0, last_entry.count}) begin
               bwr_en    = 1'b1;
               bwr_data  = '{tracked: bd.tracked, alpha: bd.alpha + 32'd1};
               status_in = STATUS_FILTERED;
               state_in  = S_OUT;
            end else begin
               hash_start = 1'b1;
               hash_key   = last_entry.key;
               hash_len   = last_entry.len;
               status_in  = STATUS_REPLACED;
               state_in   = S_HASH2;
            end
         end
         S_HASH2: begin
            if (hash_done) begin
               state_in = S_BRD2;
            end
         end
         S_BRD2: begin
            brd_addr = bkt2_ff;
            state_in = S_DEC2;
         end
         S_DEC2: begin
            // evicted key's bucket takes its count as alpha
            bwr_en = 1'b1;
            if (bkt2_ff == bkt_h_ff) begin
               bwr_addr = bkt_h_ff;
               bwr_data = '{tracked: ((bd.tracked != '0) ? bd.tracked - FW'(1) : bd.tracked)
                                     + FW'(1),
                            alpha: last_entry.count};
               load_any = 1'b1;
               load_err = last_entry.count;
               cur_in   = '0;
               cur_in[CAPACITY-1] = 1'b1;
               state_in = S_BUB;
            end else begin
               bwr_addr = bkt2_ff;
               bwr_data = '{tracked: (bd.tracked != '0) ? bd.tracked - FW'(1) : bd.tracked,
                            alpha: last_entry.count};
               state_in = S_WRH;
            end
         end
         S_WRH: begin
            bwr_en   = 1'b1;
            bwr_addr = bkt_h_ff;
            bwr_data = '{tracked: bd_h_ff.tracked + FW'(1), alpha: bd_h_ff.alpha};
            load_any = 1'b1;
            load_err = bd_h_ff.alpha;
            cur_in   = '0;
            cur_in[CAPACITY-1] = 1'b1;
            state_in = S_BUB;
         end
         S_BUB: begin
            if (swap == '0) begin
               state_in = S_OUT;
            end else begin
               for (int i = 1; i < CAPACITY; i++) begin
                  cur_in[i-1] = swap[i];
                  cur_in[i]   = 1'b0;
               end
               cur_in[CAPACITY-1] = 1'b0;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // load entry for added or replacing keys
   always_comb begin
      load_entry.key   = key_ff;
      load_entry.len   = len_ff;
      load_entry.err   = load_err;
      load_entry.count = (load_err == '1) ? load_err : load_err + 32'd1;
   end

   // per-cell controls
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cctrl[i].load      = load_any && ((state_ff == S_DEC) ? load_sel[i]
                                                               : (i == CAPACITY - 1));
         cctrl[i].inc       = inc_any && match_vec[i];
         cctrl[i].take_prev = swap[i];
         cctrl[i].take_next = (i < CAPACITY - 1) ? swap[(i < CAPACITY - 1) ? i + 1 : i]
                                                 : 1'b0;
      end
   end

   // reported entry selection
   always_comb begin
      pos_w      = 32'd0;
      pos_entry  = '0;
      rank_entry = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (cur_ff[i]) begin
            pos_w     = pos_w | 32'(i);
            pos_entry = pos_entry | cells[i];
         end
         if (32'(rrank_ff) == 32'(i)) begin
            rank_entry = cells[i];
         end
      end
      rank_hit = ({28'd0, rrank_ff} < 32'(fill_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         if ((state_ff == S_OUT) && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // item payload and work registers
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      cur_ff    <= cur_in;
      if (acc) begin
         op_ff    <= req_chan.opcode;
         key_ff   <= key_m;
         len_ff   <= len_c;
         rrank_ff <= req_chan.read_rank;
      end
      if ((state_ff == S_HASH) && hash_done) begin
         bkt_h_ff <= hash_bucket;
      end
      if ((state_ff == S_HASH2) && hash_done) begin
         bkt2_ff <= hash_bucket;
      end
      if (state_ff == S_DEC) begin
         bd_h_ff <= bd;
      end
   end

   // output register load
   always_ff @(posedge clock) begin
      if ((state_ff == S_OUT) && out_free) begin
         o_status_ff <= status_ff;
         if (op_ff == OP_READ) begin
            o_rank_ff  <= rrank_ff;
            o_valid_ff <= rank_hit;
            o_key_ff   <= rank_hit ? rank_entry.key   : 64'd0;
            o_len_ff   <= rank_hit ? rank_entry.len   : 4'd0;
            o_count_ff <= rank_hit ? rank_entry.count : 32'd0;
            o_err_ff   <= rank_hit ? rank_entry.err   : 32'd0;
         end else if (status_ff == STATUS_FILTERED) begin
            o_rank_ff  <= 4'd0;
            o_valid_ff <= 1'b0;
            o_key_ff   <= key_ff;
            o_len_ff   <= len_ff;
            o_count_ff <= 32'd0;
            o_err_ff   <= 32'd0;
         end else begin
            o_rank_ff  <= pos_w[3:0];
            o_valid_ff <= 1'b1;
            o_key_ff   <= pos_entry.key;
            o_len_ff   <= pos_entry.len;
            o_count_ff <= pos_entry.count;
            o_err_ff   <= pos_entry.err;
         end
      end
   end

   // bucket memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (bwr_en) begin
         bmem[bwr_addr] <= bwr_data;
      end
      brd_data_ff <= bmem[brd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bvalid_ff    <= '0;
         brd_valid_ff <= 1'b0;
      end else begin
         if (bwr_en) begin
            bvalid_ff[bwr_addr] <= 1'b1;
         end
         brd_valid_ff <= bvalid_ff[brd_addr];
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.status      = o_status_ff;
   assign rsp_chan.rank        = o_rank_ff;
   assign rsp_chan.entry_valid = o_valid_ff;
   assign rsp_chan.out_key     = o_key_ff;
   assign rsp_chan.out_len     = o_len_ff;
   assign rsp_chan.count       = o_count_ff;
   assign rsp_chan.error_bound = o_err_ff;

   // fill level stays within the list
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CAP_F)
      else $error("fill level beyond capacity");

   // exactly one slot is current while bubbling
   a_cur_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BUB) |-> $onehot(cur_ff))
      else $error("bubble position not one-hot");

   // an accepted item always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      acc |=> (state_ff != S_IDLE))
      else $error("accepted item dropped");

   // at most one list entry matches a key
   a_match_unique: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DEC) |-> $onehot0(match_vec))
      else $error("duplicate key in list");

endmodule

`default_nettype wire
